/* src/ble_sensor_beacon_decoder_assert.svh */
// Assertion macros for the sensor beacon decoder checker
`ifndef BLE_SENSOR_BEACON_DECODER_ASSERT_SVH
`define BLE_SENSOR_BEACON_DECODER_ASSERT_SVH

// same-cycle implication
`define BSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bsd_pkg.sv */
// Types and constants of the sensor beacon decoder
package bsd_pkg;

  localparam int SLOT_COUNT  = 5;
  localparam int REG_COUNT   = 5;
  localparam int STORE_DEPTH = 17;
  localparam int POS_W       = 5;
  localparam int ADDR_W      = 48;
  localparam int SLOT_W      = 3;
  localparam int CFG_IDX_W   = 3;

  localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
  localparam logic [POS_W-1:0] LEN_MIN  = 5'd3;
  localparam logic [POS_W-1:0] LEN_FMT3 = 5'd16;
  localparam logic [POS_W-1:0] LEN_FMT5 = 5'd17;

  localparam logic [7:0] FMT_CODE_3 = 8'd3;
  localparam logic [7:0] FMT_CODE_5 = 8'd5;

  localparam logic FORMAT_KIND_3 = 1'b0;
  localparam logic FORMAT_KIND_5 = 1'b1;

  localparam logic [16:0] KELVIN_X200      = 17'd54630;
  localparam logic [16:0] PRESSURE_BASE_PA = 17'd50000;
  localparam logic [15:0] SUPPLY_BASE_MV   = 16'd1600;
  localparam logic [14:0] TEMP_DEG_SCALE   = 15'd200;
  localparam logic [15:0] HUM_SCALE        = 16'd200;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  typedef struct packed {
    logic                    valid;
    logic [POS_W-1:0]        len;
    logic [ADDR_W-1:0]       addr;
    logic signed [7:0]       sig;
  } pend_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              format_kind;
    logic [16:0]       temperature_kelvin_x200;
    logic [15:0]       humidity_ratio_x40000;
    logic [16:0]       pressure_pa;
    logic [15:0]       supply_mv;
    logic signed [7:0] signal_out_dbm;
  } out_item_t;

  function automatic int reg_slots(input int slots);
    return (slots < REG_COUNT) ? slots : REG_COUNT;
  endfunction

endpackage

/* src/bsd_ifs.sv */
// Channel interfaces of the sensor beacon decoder
interface bsd_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        payload_byte;
  logic              final_byte;
  logic [47:0]       sender_address;
  logic signed [7:0] signal_dbm;

  modport source(output valid, payload_byte, final_byte, sender_address, signal_dbm,
                 input ready);
  modport sink(input valid, payload_byte, final_byte, sender_address, signal_dbm,
               output ready);
endinterface

interface bsd_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        slot_index;
  logic              format_kind;
  logic [16:0]       temperature_kelvin_x200;
  logic [15:0]       humidity_ratio_x40000;
  logic [16:0]       pressure_pa;
  logic [15:0]       supply_mv;
  logic signed [7:0] signal_out_dbm;

  modport source(output valid, slot_index, format_kind, temperature_kelvin_x200,
                 humidity_ratio_x40000, pressure_pa, supply_mv, signal_out_dbm,
                 input ready);
  modport sink(input valid, slot_index, format_kind, temperature_kelvin_x200,
               humidity_ratio_x40000, pressure_pa, supply_mv, signal_out_dbm,
               output ready);
endinterface

interface bsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* src/bsd_allow_regs.sv */
// Allowlist address registers written through the configuration channel
module bsd_allow_regs #(
  parameter int SLOT_COUNT = bsd_pkg::SLOT_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  bsd_cfg_if.sink cfg_ch,
  output logic [bsd_pkg::reg_slots(SLOT_COUNT)-1:0][bsd_pkg::ADDR_W-1:0] allow_addr
);

  localparam int NREG = bsd_pkg::reg_slots(SLOT_COUNT);

  logic [NREG-1:0][bsd_pkg::ADDR_W-1:0] allow_r;

  assign cfg_ch.ready = 1'b1;
  assign allow_addr   = allow_r;

  for (genvar i = 0; i < NREG; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        allow_r[i] <= '0;
      end else if (cfg_ch.valid && cfg_ch.index == bsd_pkg::CFG_IDX_W'(i)) begin
        allow_r[i] <= cfg_ch.data;
      end
    end
  end

endmodule

/* src/bsd_capture.sv */
// Byte counter, payload store and pending-decode register
module bsd_capture (
  input  logic clk,
  input  logic rst_n,
  bsd_in_if.sink in_ch,
  input  logic dec_free,
  output bsd_pkg::store_t store,
  output bsd_pkg::pend_t  pend
);

  logic [bsd_pkg::POS_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic [7:0]                 store_r [bsd_pkg::STORE_DEPTH];
  logic                       pend_v_r, pend_v_nxt;
  logic [bsd_pkg::POS_W-1:0]  pend_len_r;
  logic [bsd_pkg::ADDR_W-1:0] pend_addr_r;
  logic signed [7:0]          pend_sig_r;
  logic                       accept;

  assign in_ch.ready = !pend_v_r || dec_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_inc     = (pos_r < bsd_pkg::POS_MAX) ? pos_r + 5'd1 : pos_r;

  always_comb begin
    pos_nxt    = pos_r;
    pend_v_nxt = pend_v_r && !dec_free;
    if (accept) begin
      pos_nxt = in_ch.final_byte ? '0 : pos_inc;
      if (in_ch.final_byte) begin
        pend_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.final_byte) begin
      pend_len_r  <= pos_inc;
      pend_addr_r <= in_ch.sender_address;
      pend_sig_r  <= in_ch.signal_dbm;
    end
  end

  for (genvar i = 0; i < bsd_pkg::STORE_DEPTH; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (accept && pos_r == bsd_pkg::POS_W'(i)) begin
        store_r[i] <= in_ch.payload_byte;
      end
    end
    assign store[i] = store_r[i];
  end

  assign pend.valid = pend_v_r;
  assign pend.len   = pend_len_r;
  assign pend.addr  = pend_addr_r;
  assign pend.sig   = pend_sig_r;

endmodule

/* src/bsd_decode.sv */
// Allowlist match, format decode and result register
module bsd_decode #(
  parameter int SLOT_COUNT = bsd_pkg::SLOT_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  input  bsd_pkg::store_t store,
  input  bsd_pkg::pend_t  pend,
  input  logic [bsd_pkg::reg_slots(SLOT_COUNT)-1:0][bsd_pkg::ADDR_W-1:0] allow_addr,
  output logic dec_free,
  bsd_out_if.source out_ch
);

  localparam int NREG = bsd_pkg::reg_slots(SLOT_COUNT);

  logic                 out_v_r, out_v_nxt;
  bsd_pkg::out_item_t   out_r, out_nxt;
  logic                 hit;
  logic                 slot_hit;
  logic [bsd_pkg::SLOT_W-1:0] slot;
  logic [14:0]          mag3;
  logic [15:0]          raw5;
  logic [15:0]          pres_raw;

  assign dec_free = !out_v_r || out_ch.ready;

  always_comb begin
    slot_hit = 1'b0;
    slot     = '0;
    for (int i = NREG - 1; i >= 0; i--) begin
      if (allow_addr[i] != '0 && allow_addr[i] == pend.addr) begin
        slot_hit = 1'b1;
        slot     = bsd_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    mag3     = 15'(15'(store[4][6:0]) * bsd_pkg::TEMP_DEG_SCALE) + 15'({store[5], 1'b0});
    raw5     = {store[3], store[4]};
    pres_raw = '0;
    hit      = 1'b0;
    out_nxt  = out_r;
    out_nxt.slot_index     = slot;
    out_nxt.signal_out_dbm = pend.sig;
    unique case (store[2])
      bsd_pkg::FMT_CODE_3: begin
        hit                           = pend.len >= bsd_pkg::LEN_FMT3;
        pres_raw                      = {store[6], store[7]};
        out_nxt.format_kind           = bsd_pkg::FORMAT_KIND_3;
        out_nxt.temperature_kelvin_x200 = store[4][7] ?
          bsd_pkg::KELVIN_X200 - 17'(mag3) : bsd_pkg::KELVIN_X200 + 17'(mag3);
        out_nxt.humidity_ratio_x40000 = 16'(16'(store[3]) * bsd_pkg::HUM_SCALE);
        out_nxt.supply_mv             = {store[14], store[15]};
      end
      bsd_pkg::FMT_CODE_5: begin
        hit                           = pend.len >= bsd_pkg::LEN_FMT5;
        pres_raw                      = {store[7], store[8]};
        out_nxt.format_kind           = bsd_pkg::FORMAT_KIND_5;
        out_nxt.temperature_kelvin_x200 = raw5[15] ?
          bsd_pkg::KELVIN_X200 - (17'h10000 - 17'(raw5)) :
          bsd_pkg::KELVIN_X200 + 17'(raw5);
        out_nxt.humidity_ratio_x40000 = {store[5], store[6]};
        out_nxt.supply_mv             = 16'({store[15], store[16][7:5]}) +
                                        bsd_pkg::SUPPLY_BASE_MV;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    out_nxt.pressure_pa = 17'(pres_raw) + bsd_pkg::PRESSURE_BASE_PA;
    hit       = hit && slot_hit && pend.len >= bsd_pkg::LEN_MIN;
    out_v_nxt = dec_free ? (pend.valid && hit) : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_free && pend.valid && hit) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid                   = out_v_r;
  assign out_ch.slot_index              = out_r.slot_index;
  assign out_ch.format_kind             = out_r.format_kind;
  assign out_ch.temperature_kelvin_x200 = out_r.temperature_kelvin_x200;
  assign out_ch.humidity_ratio_x40000   = out_r.humidity_ratio_x40000;
  assign out_ch.pressure_pa             = out_r.pressure_pa;
  assign out_ch.supply_mv               = out_r.supply_mv;
  assign out_ch.signal_out_dbm          = out_r.signal_out_dbm;

endmodule

/* src/ble_sensor_beacon_decoder.sv */
// Top level of the sensor beacon decoder
//
//   channel  dir  carries
//   in_ch    in   payload byte, final flag, sender address, signal dBm
//   out_ch   out  slot, format, temperature, humidity, pressure, supply, signal
//   cfg_ch   in   allowlist slot index and address
//
// One item accepted per cycle when not stalled; store write and counter are registered.
// A final byte's result passes through the pending register, then the result register.
// Reset clears the counter, allowlist and valid flags; no clearing pass is run.
// A stalled result holds; a final byte waits in the pending register and then
// blocks new items until the result register frees.
module ble_sensor_beacon_decoder #(
  parameter int SLOT_COUNT = bsd_pkg::SLOT_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  bsd_in_if.sink    in_ch,
  bsd_out_if.source out_ch,
  bsd_cfg_if.sink   cfg_ch
);

  localparam int NREG = bsd_pkg::reg_slots(SLOT_COUNT);

  logic [NREG-1:0][bsd_pkg::ADDR_W-1:0] allow_addr;
  bsd_pkg::store_t store;
  bsd_pkg::pend_t  pend;
  logic            dec_free;

  bsd_allow_regs #(.SLOT_COUNT(SLOT_COUNT)) u_allow (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .allow_addr (allow_addr)
  );

  bsd_capture u_capture (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dec_free (dec_free),
    .store    (store),
    .pend     (pend)
  );

  bsd_decode #(.SLOT_COUNT(SLOT_COUNT)) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .store      (store),
    .pend       (pend),
    .allow_addr (allow_addr),
    .dec_free   (dec_free),
    .out_ch     (out_ch)
  );

endmodule

/* src/bsd_checker.sv */
// Port-level checker for the sensor beacon decoder and its bind
`include "ble_sensor_beacon_decoder_assert.svh"

module bsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_final,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_slot,
  input logic        out_kind,
  input logic [16:0] out_temp,
  input logic [15:0] out_hum,
  input logic [16:0] out_pres,
  input logic [15:0] out_mv,
  input logic [7:0]  out_sig
);

  localparam logic [16:0] TEMP3_LOW  = 17'd28720;
  localparam logic [16:0] TEMP3_HIGH = 17'd80540;
  localparam logic [2:0]  SLOT_LAST  = 3'(bsd_pkg::REG_COUNT - 1);

  `BSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_slot) && $stable(out_kind) && $stable(out_temp) &&
    $stable(out_hum) && $stable(out_pres) && $stable(out_mv) && $stable(out_sig),
    "result changed while stalled")
  `BSD_ASSERT_NOW(a_slot_range, out_valid, out_slot <= SLOT_LAST,
    "slot index beyond allowlist")
  `BSD_ASSERT_NOW(a_fmt3_temp, out_valid && out_kind == bsd_pkg::FORMAT_KIND_3,
    out_temp >= TEMP3_LOW && out_temp <= TEMP3_HIGH, "format 3 temperature out of range")
  `BSD_ASSERT_NOW(a_result_origin, $rose(out_valid),
    $past(in_valid && in_ready && in_final, 2), "result without a final byte")
  `BSD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready,
    "input stalled without output stall")

endmodule

bind ble_sensor_beacon_decoder bsd_checker u_bsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_slot  (out_ch.slot_index),
  .out_kind  (out_ch.format_kind),
  .out_temp  (out_ch.temperature_kelvin_x200),
  .out_hum   (out_ch.humidity_ratio_x40000),
  .out_pres  (out_ch.pressure_pa),
  .out_mv    (out_ch.supply_mv),
  .out_sig   (out_ch.signal_out_dbm)
);

/* dv/tb.sv */
// Self-checking testbench for the sensor beacon decoder: random advertisements, scored results
module tb;

  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 400;

  typedef struct {
    logic [7:0]        payload_byte;
    logic              final_byte;
    logic [47:0]       sender_address;
    logic signed [7:0] signal_dbm;
  } beacon_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  bsd_in_if  in_if();
  bsd_out_if out_if();
  bsd_cfg_if cfg_if();

  ble_sensor_beacon_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  beacon_byte_t        pending_bytes[$];
  bsd_pkg::out_item_t  expected_readings[$];
  beacon_byte_t        next_byte;

  logic [47:0] allow_copy [bsd_pkg::REG_COUNT] = '{default: '0};
  logic [47:0] boundary_slots [bsd_pkg::REG_COUNT] =
    '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h1, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF};
  logic [7:0]  payload_copy [bsd_pkg::STORE_DEPTH];
  logic [bsd_pkg::POS_W-1:0] byte_count = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int hold_request   = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [47:0] random_address();
    return 48'({$urandom, $urandom});
  endfunction

  // track the byte count and store, decode on the final byte
  function automatic void predict_reading(input beacon_byte_t b);
    logic [bsd_pkg::POS_W-1:0] len;
    logic [7:0] fmt;
    int slot;
    int mag;
    int kelvin;
    logic [15:0] raw;
    bsd_pkg::out_item_t r;
    if (byte_count < bsd_pkg::STORE_DEPTH) payload_copy[byte_count] = b.payload_byte;
    if (byte_count != bsd_pkg::POS_MAX) byte_count = byte_count + 1'b1;
    if (!b.final_byte) return;
    len = byte_count;
    byte_count = '0;
    if (len < bsd_pkg::LEN_MIN) return;
    fmt = payload_copy[2];
    slot = -1;
    for (int i = bsd_pkg::REG_COUNT - 1; i >= 0; i--) begin
      if (allow_copy[i] != '0 && allow_copy[i] == b.sender_address) slot = i;
    end
    if (slot < 0) return;
    kelvin = int'(bsd_pkg::KELVIN_X200);
    if (fmt == bsd_pkg::FMT_CODE_3) begin
      if (len < bsd_pkg::LEN_FMT3) return;
      mag = 200 * int'(payload_copy[4][6:0]) + 2 * int'(payload_copy[5]);
      r.format_kind = bsd_pkg::FORMAT_KIND_3;
      r.temperature_kelvin_x200 = 17'(payload_copy[4][7] ? kelvin - mag : kelvin + mag);
      r.humidity_ratio_x40000 = 16'(200 * int'(payload_copy[3]));
      r.pressure_pa = 17'(int'({payload_copy[6], payload_copy[7]})
                          + int'(bsd_pkg::PRESSURE_BASE_PA));
      r.supply_mv = {payload_copy[14], payload_copy[15]};
    end else if (fmt == bsd_pkg::FMT_CODE_5) begin
      if (len < bsd_pkg::LEN_FMT5) return;
      raw = {payload_copy[3], payload_copy[4]};
      r.format_kind = bsd_pkg::FORMAT_KIND_5;
      r.temperature_kelvin_x200 = 17'(kelvin + int'($signed(raw)));
      r.humidity_ratio_x40000 = {payload_copy[5], payload_copy[6]};
      r.pressure_pa = 17'(int'({payload_copy[7], payload_copy[8]})
                          + int'(bsd_pkg::PRESSURE_BASE_PA));
      r.supply_mv = 16'(int'({payload_copy[15], payload_copy[16]} >> 5)
                        + int'(bsd_pkg::SUPPLY_BASE_MV));
    end else begin
      return;
    end
    r.slot_index = bsd_pkg::SLOT_W'(slot);
    r.signal_out_dbm = b.signal_dbm;
    expected_readings.push_back(r);
  endfunction

  function automatic void check_field(input string field, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // fill < 0 gives random content; the format byte always sits at position 2
  function automatic void queue_advert(input logic [7:0] fmt, input int len,
                                       input logic [47:0] addr, input logic signed [7:0] sig,
                                       input int fill);
    beacon_byte_t b;
    for (int i = 0; i < len; i++) begin
      b.payload_byte = (i == 2) ? fmt : (fill < 0) ? 8'($urandom) : 8'(fill);
      b.final_byte = (i == len - 1);
      b.sender_address = b.final_byte ? addr : random_address();
      b.signal_dbm = b.final_byte ? sig : 8'($urandom);
      pending_bytes.push_back(b);
    end
  endfunction

  function automatic logic [47:0] pick_address();
    int r = $urandom_range(9);
    if (r < 8) return allow_copy[bsd_pkg::CFG_IDX_W'($urandom_range(bsd_pkg::REG_COUNT - 1))];
    if (r == 8) return random_address();
    return '0;
  endfunction

  function automatic void queue_random_advert();
    int kind = $urandom_range(99);
    logic [7:0] fmt;
    int len;
    fmt = $urandom_range(1) ? bsd_pkg::FMT_CODE_5 : bsd_pkg::FMT_CODE_3;
    if (kind < 80) begin
      len = (fmt == bsd_pkg::FMT_CODE_5) ? 17 : $urandom_range(16, 17);
    end else if (kind < 88) begin
      len = $urandom_range(1, (fmt == bsd_pkg::FMT_CODE_5) ? 16 : 15);
    end else if (kind < 94) begin
      fmt = 8'($urandom);
      len = $urandom_range(1, 20);
    end else begin
      len = $urandom_range(18, 40);
    end
    queue_advert(fmt, len, pick_address(), 8'($urandom), -1);
  endfunction

  task automatic write_allow_slot(input logic [bsd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [47:0] addr);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= addr;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx < bsd_pkg::REG_COUNT) allow_copy[idx] = addr;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_if.valid || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        next_byte.payload_byte = in_if.payload_byte;
        next_byte.final_byte = in_if.final_byte;
        next_byte.sender_address = in_if.sender_address;
        next_byte.signal_dbm = in_if.signal_dbm;
        predict_reading(next_byte);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          in_if.payload_byte <= next_byte.payload_byte;
          in_if.final_byte <= next_byte.final_byte;
          in_if.sender_address <= next_byte.sender_address;
          in_if.signal_dbm <= next_byte.signal_dbm;
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_request != hold_served) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_request;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    bsd_pkg::out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading with none expected: slot %0d temperature %0d",
                 out_if.slot_index, out_if.temperature_kelvin_x200);
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("slot_index", 17'(want.slot_index), 17'(out_if.slot_index));
          check_field("format_kind", 17'(want.format_kind), 17'(out_if.format_kind));
          check_field("temperature_kelvin_x200", want.temperature_kelvin_x200,
                      out_if.temperature_kelvin_x200);
          check_field("humidity_ratio_x40000", 17'(want.humidity_ratio_x40000),
                      17'(out_if.humidity_ratio_x40000));
          check_field("pressure_pa", want.pressure_pa, out_if.pressure_pa);
          check_field("supply_mv", 17'(want.supply_mv), 17'(out_if.supply_mv));
          check_field("signal_out_dbm", {9'd0, want.signal_out_dbm},
                      {9'd0, out_if.signal_out_dbm});
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                 || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload_byte = '0;
    in_if.final_byte = 1'b0;
    in_if.sender_address = '0;
    in_if.signal_dbm = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty allowlist: a zero address must not match
    queue_advert(bsd_pkg::FMT_CODE_5, 17, '0, 8'sd5, -1);
    wait_idle();

    for (int s = 0; s < bsd_pkg::REG_COUNT; s++) begin
      write_allow_slot(bsd_pkg::CFG_IDX_W'(s), boundary_slots[s]);
    end
    write_allow_slot(3'd7, random_address());
    @(negedge clk);

    queue_advert(bsd_pkg::FMT_CODE_3, 16, 48'hFFFF_FFFF_FFFF, -8'sd128, 8'h00);
    queue_advert(bsd_pkg::FMT_CODE_3, 16, 48'h1, 8'sd127, 8'hFF);
    queue_advert(bsd_pkg::FMT_CODE_3, 17, 48'h8000_0000_0000, 8'sd0, 8'h80);
    queue_advert(bsd_pkg::FMT_CODE_5, 17, 48'h8000_0000_0000, -8'sd1, 8'hFF);
    queue_advert(bsd_pkg::FMT_CODE_5, 17, 48'hFFFF_FFFF_FFFF, 8'sd64, 8'h80);
    queue_advert(bsd_pkg::FMT_CODE_5, 17, 48'h1, -8'sd64, 8'h7F);
    queue_advert(bsd_pkg::FMT_CODE_5, 17, 48'h1, 8'sd1, 8'h00);
    queue_advert(bsd_pkg::FMT_CODE_3, 15, 48'h1, 8'sd2, -1);
    queue_advert(bsd_pkg::FMT_CODE_5, 16, 48'h1, 8'sd3, -1);
    queue_advert(8'h04, 17, 48'h1, 8'sd4, -1);
    queue_advert(8'hFF, 17, 48'h1, 8'sd4, -1);
    queue_advert(bsd_pkg::FMT_CODE_5, 1, 48'h1, 8'sd6, -1);
    queue_advert(bsd_pkg::FMT_CODE_5, 2, 48'h1, 8'sd7, -1);
    queue_advert(bsd_pkg::FMT_CODE_5, 40, 48'hFFFF_FFFF_FFFF, -8'sd9, -1);
    queue_advert(bsd_pkg::FMT_CODE_3, 33, 48'h1, 8'sd10, -1);
    queue_advert(bsd_pkg::FMT_CODE_5, 17, 48'h7FFF_FFFF_FFFE, 8'sd11, -1);
    queue_advert(bsd_pkg::FMT_CODE_3, 16, '0, 8'sd12, -1);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 25 : 0;
      recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 25 : 0;
      for (int s = 0; s < bsd_pkg::REG_COUNT; s++) begin
        write_allow_slot(bsd_pkg::CFG_IDX_W'(s), (phase == 1) ? boundary_slots[s]
                         : ($urandom_range(7) == 0) ? 48'h0 : random_address());
      end
      @(negedge clk);
      while (pending_bytes.size() < PHASE_BYTES) queue_random_advert();
      // hold off the receiver so the block backs up into its input
      if (phase == 0) hold_request = hold_request + 1;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/bsd_pkg.sv
src/bsd_ifs.sv
src/bsd_allow_regs.sv
src/bsd_capture.sv
src/bsd_decode.sv
src/ble_sensor_beacon_decoder.sv
src/bsd_checker.sv
dv/tb.sv
